>>> hdl/emtc_pkg.sv
package emtc_pkg;

    localparam int NSTAGES = 12;
    localparam int DEC_STAGES = 5;
    localparam int DLY_STAGES = NSTAGES - DEC_STAGES;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [41:0] epoch_ms_in;
        logic [55:0] packed_time_in;
    } req_t;

    typedef struct packed {
        logic [55:0] packed_time_out;
        logic [42:0] epoch_ms_out;
    } rsp_t;

    // Days before the first of a March-based month, offset as in the decode formula.
    function automatic logic [8:0] mon_days(input logic [3:0] mon);
        logic [8:0] r;
        begin
            case (mon)
                4'd2:    r = 9'd122;
                4'd3:    r = 9'd153;
                4'd4:    r = 9'd183;
                4'd5:    r = 9'd214;
                4'd6:    r = 9'd244;
                4'd7:    r = 9'd275;
                4'd8:    r = 9'd306;
                4'd9:    r = 9'd336;
                4'd10:   r = 9'd367;
                4'd11:   r = 9'd397;
                4'd12:   r = 9'd428;
                4'd13:   r = 9'd459;
                4'd14:   r = 9'd489;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> hdl/emtc_enc.sv
module emtc_enc (
    input  logic                             clk,
    input  logic [emtc_pkg::NSTAGES-1:0]     adv,
    input  emtc_pkg::req_t                   req,
    output logic [55:0]                      word
);
    import emtc_pkg::*;

    // Stage 1
    logic [28:0] e1_t_reg, e1_t_next;
    logic [32:0] e1_qa_reg, e1_qa_next;
    // Stage 2
    logic [48:0] e2_prod;
    logic [19:0] e2_q0_reg;
    logic [28:0] e2_t_reg;
    logic [32:0] e2_qa_reg;
    // Stage 3
    logic [28:0] e3_r;
    logic        e3_sel;
    logic [9:0]  e3_msec_reg, e3_msec_next;
    logic [32:0] e3_secs_reg, e3_secs_next;
    // Stage 4
    logic [42:0] e4_prod;
    logic [16:0] e4_q0_reg;
    logic [25:0] e4_x_reg;
    logic [6:0]  e4_lo_reg;
    logic [9:0]  e4_msec_reg;
    // Stage 5
    logic [25:0] e5_r;
    logic        e5_sel;
    logic [15:0] e5_days_reg, e5_days_next;
    logic [16:0] e5_sod_reg, e5_sod_next;
    logic [9:0]  e5_msec_reg;
    // Stage 6
    logic [14:0] e6_xs;
    logic [26:0] e6_p;
    logic [11:0] e6_q0;
    logic [14:0] e6_r;
    logic        e6_sel;
    logic [19:0] e6_z;
    logic [22:0] e6_pz;
    logic [2:0]  e6_e0;
    logic [19:0] e6_rz;
    logic        e6_selz;
    logic [10:0] e6_mod_reg, e6_mod_next;
    logic [5:0]  e6_sec_reg, e6_sec_next;
    logic [2:0]  e6_era_reg, e6_era_next;
    logic [17:0] e6_doe_reg, e6_doe_next;
    logic [9:0]  e6_msec_reg;
    // Stage 7
    logic [16:0] e7_p;
    logic [5:0]  e7_hq;
    logic [10:0] e7_rm;
    logic        e7_sel;
    logic [25:0] e7_p1;
    logic [7:0]  e7_q1;
    logic [17:0] e7_r1;
    logic [7:0]  e7_d1;
    logic [20:0] e7_p2;
    logic [2:0]  e7_q2;
    logic [17:0] e7_r2;
    logic [2:0]  e7_d2;
    logic        e7_d3;
    logic [4:0]  e7_hour_reg, e7_hour_next;
    logic [5:0]  e7_min_reg, e7_min_next;
    logic [17:0] e7_ysum_reg, e7_ysum_next;
    logic [17:0] e7_doe_reg;
    logic [2:0]  e7_era_reg;
    logic [5:0]  e7_sec_reg;
    logic [9:0]  e7_msec_reg;
    // Stage 8
    logic [27:0] e8_p;
    logic [9:0]  e8_q;
    logic [17:0] e8_r;
    logic        e8_sel;
    logic [8:0]  e8_yoe_reg, e8_yoe_next;
    logic [17:0] e8_doe_reg;
    logic [2:0]  e8_era_reg;
    logic [4:0]  e8_hour_reg;
    logic [5:0]  e8_min_reg;
    logic [5:0]  e8_sec_reg;
    logic [9:0]  e8_msec_reg;
    // Stage 9
    logic [11:0] e9_p;
    logic [2:0]  e9_cq;
    logic [8:0]  e9_rc;
    logic        e9_sel;
    logic [2:0]  e9_c;
    logic [17:0] e9_base;
    logic [8:0]  e9_doy_reg, e9_doy_next;
    logic [11:0] e9_year_reg, e9_year_next;
    logic [4:0]  e9_hour_reg;
    logic [5:0]  e9_min_reg;
    logic [5:0]  e9_sec_reg;
    logic [9:0]  e9_msec_reg;
    // Stage 10
    logic [10:0] e10_v;
    logic [14:0] e10_p;
    logic [3:0]  e10_mq;
    logic [10:0] e10_rv;
    logic        e10_sel;
    logic [3:0]  e10_mp_reg, e10_mp_next;
    logic [8:0]  e10_doy_reg;
    logic [11:0] e10_year_reg;
    logic [4:0]  e10_hour_reg;
    logic [5:0]  e10_min_reg;
    logic [5:0]  e10_sec_reg;
    logic [9:0]  e10_msec_reg;
    // Stage 11
    logic [10:0] e11_w;
    logic [19:0] e11_p;
    logic [8:0]  e11_q0;
    logic [10:0] e11_rw;
    logic        e11_sel;
    logic [8:0]  e11_qd;
    logic        e11_late;
    logic [4:0]  e11_mday_reg, e11_mday_next;
    logic [3:0]  e11_month_reg, e11_month_next;
    logic [11:0] e11_year_reg, e11_year_next;
    logic [4:0]  e11_hour_reg;
    logic [5:0]  e11_min_reg;
    logic [5:0]  e11_sec_reg;
    logic [9:0]  e11_msec_reg;
    // Stage 12
    logic [17:0] e12_p;
    logic [5:0]  e12_yq;
    logic [11:0] e12_ry;
    logic        e12_sel;
    logic [6:0]  e12_y2;
    logic [15:0] e12_w16;
    logic [55:0] e12_word_reg, e12_word_next;

    always_comb
    begin
        e1_t_next  = ({8'd0, req.epoch_ms_in[41:21]} * 29'd152)
                   + {8'd0, req.epoch_ms_in[20:0]};
        e1_qa_next = {12'd0, req.epoch_ms_in[41:21]} * 33'd2097;

        e2_prod = {20'd0, e1_t_reg} * 49'd536870;

        e3_r         = e2_t_reg - ({9'd0, e2_q0_reg} * 29'd1000);
        e3_sel       = (e3_r >= 29'd1000);
        e3_msec_next = e3_sel ? 10'(e3_r - 29'd1000) : e3_r[9:0];
        e3_secs_next = e2_qa_reg + {13'd0, e2_q0_reg} + {32'd0, e3_sel};

        e4_prod = {17'd0, e3_secs_reg[32:7]} * 43'd99420;

        e5_r         = e4_x_reg - ({9'd0, e4_q0_reg} * 26'd675);
        e5_sel       = (e5_r >= 26'd675);
        e5_days_next = 16'(e4_q0_reg + {16'd0, e5_sel});
        e5_sod_next  = {(e5_sel ? 10'(e5_r - 26'd675) : e5_r[9:0]), e4_lo_reg};

        e6_xs       = e5_sod_reg[16:2];
        e6_p        = {12'd0, e6_xs} * 27'd2184;
        e6_q0       = e6_p[26:15];
        e6_r        = e6_xs - ({3'd0, e6_q0} * 15'd15);
        e6_sel      = (e6_r >= 15'd15);
        e6_mod_next = 11'(e6_q0 + {11'd0, e6_sel});
        e6_sec_next = {(e6_sel ? 4'(e6_r - 15'd15) : e6_r[3:0]), e5_sod_reg[1:0]};
        e6_z        = {4'd0, e5_days_reg} + 20'd719468;
        e6_pz       = {3'd0, e6_z} * 23'd7;
        e6_e0       = e6_pz[22:20];
        e6_rz       = e6_z - ({17'd0, e6_e0} * 20'd146097);
        e6_selz     = (e6_rz >= 20'd146097);
        e6_era_next = e6_e0 + {2'd0, e6_selz};
        e6_doe_next = e6_selz ? 18'(e6_rz - 20'd146097) : e6_rz[17:0];

        e7_p         = {6'd0, e6_mod_reg} * 17'd34;
        e7_hq        = e7_p[16:11];
        e7_rm        = e6_mod_reg - ({5'd0, e7_hq} * 11'd60);
        e7_sel       = (e7_rm >= 11'd60);
        e7_hour_next = 5'(e7_hq + {5'd0, e7_sel});
        e7_min_next  = e7_sel ? 6'(e7_rm - 11'd60) : e7_rm[5:0];
        e7_p1        = {8'd0, e6_doe_reg} * 26'd179;
        e7_q1        = e7_p1[25:18];
        e7_r1        = e6_doe_reg - ({10'd0, e7_q1} * 18'd1460);
        e7_d1        = e7_q1 + {7'd0, (e7_r1 >= 18'd1460)};
        e7_p2        = {3'd0, e6_doe_reg} * 21'd7;
        e7_q2        = e7_p2[20:18];
        e7_r2        = e6_doe_reg - ({15'd0, e7_q2} * 18'd36524);
        e7_d2        = e7_q2 + {2'd0, (e7_r2 >= 18'd36524)};
        e7_d3        = (e6_doe_reg == 18'd146096);
        e7_ysum_next = e6_doe_reg - {10'd0, e7_d1} + {15'd0, e7_d2} - {17'd0, e7_d3};

        e8_p        = {10'd0, e7_ysum_reg} * 28'd718;
        e8_q        = e8_p[27:18];
        e8_r        = e7_ysum_reg - ({8'd0, e8_q} * 18'd365);
        e8_sel      = (e8_r >= 18'd365);
        e8_yoe_next = 9'(e8_q + {9'd0, e8_sel});

        e9_p         = {3'd0, e8_yoe_reg} * 12'd5;
        e9_cq        = e9_p[11:9];
        e9_rc        = e8_yoe_reg - ({6'd0, e9_cq} * 9'd100);
        e9_sel       = (e9_rc >= 9'd100);
        e9_c         = e9_cq + {2'd0, e9_sel};
        e9_base      = ({9'd0, e8_yoe_reg} * 18'd365) + {11'd0, e8_yoe_reg[8:2]}
                     - {15'd0, e9_c};
        e9_doy_next  = 9'(e8_doe_reg - e9_base);
        e9_year_next = {3'd0, e8_yoe_reg} + ({9'd0, e8_era_reg} * 12'd400);

        e10_v       = ({2'd0, e9_doy_reg} * 11'd5) + 11'd2;
        e10_p       = {4'd0, e10_v} * 15'd13;
        e10_mq      = e10_p[14:11];
        e10_rv      = e10_v - ({7'd0, e10_mq} * 11'd153);
        e10_sel     = (e10_rv >= 11'd153);
        e10_mp_next = e10_mq + {3'd0, e10_sel};

        e11_w          = ({7'd0, e10_mp_reg} * 11'd153) + 11'd2;
        e11_p          = {9'd0, e11_w} * 20'd409;
        e11_q0         = e11_p[19:11];
        e11_rw         = e11_w - ({2'd0, e11_q0} * 11'd5);
        e11_sel        = (e11_rw >= 11'd5);
        e11_qd         = e11_q0 + {8'd0, e11_sel};
        e11_mday_next  = 5'(e10_doy_reg - e11_qd + 9'd1);
        e11_late       = (e10_mp_reg >= 4'd10);
        e11_month_next = e11_late ? (e10_mp_reg - 4'd9) : (e10_mp_reg + 4'd3);
        e11_year_next  = e10_year_reg + {11'd0, e11_late};

        e12_p    = {6'd0, e11_year_reg} * 18'd40;
        e12_yq   = e12_p[17:12];
        e12_ry   = e11_year_reg - ({6'd0, e12_yq} * 12'd100);
        e12_sel  = (e12_ry >= 12'd100);
        e12_y2   = e12_sel ? 7'(e12_ry - 12'd100) : e12_ry[6:0];
        e12_w16  = 16'(({10'd0, e11_sec_reg} * 16'd1000) + {6'd0, e11_msec_reg});
        e12_word_next = {1'b0, e12_y2, 4'd0, e11_month_reg, 3'd0, e11_mday_reg,
                         3'd0, e11_hour_reg, 2'd0, e11_min_reg, e12_w16};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e1_t_reg  <= e1_t_next;
            e1_qa_reg <= e1_qa_next;
        end
        if (adv[1])
        begin
            e2_q0_reg <= e2_prod[48:29];
            e2_t_reg  <= e1_t_reg;
            e2_qa_reg <= e1_qa_reg;
        end
        if (adv[2])
        begin
            e3_msec_reg <= e3_msec_next;
            e3_secs_reg <= e3_secs_next;
        end
        if (adv[3])
        begin
            e4_q0_reg   <= e4_prod[42:26];
            e4_x_reg    <= e3_secs_reg[32:7];
            e4_lo_reg   <= e3_secs_reg[6:0];
            e4_msec_reg <= e3_msec_reg;
        end
        if (adv[4])
        begin
            e5_days_reg <= e5_days_next;
            e5_sod_reg  <= e5_sod_next;
            e5_msec_reg <= e4_msec_reg;
        end
        if (adv[5])
        begin
            e6_mod_reg  <= e6_mod_next;
            e6_sec_reg  <= e6_sec_next;
            e6_era_reg  <= e6_era_next;
            e6_doe_reg  <= e6_doe_next;
            e6_msec_reg <= e5_msec_reg;
        end
        if (adv[6])
        begin
            e7_hour_reg <= e7_hour_next;
            e7_min_reg  <= e7_min_next;
            e7_ysum_reg <= e7_ysum_next;
            e7_doe_reg  <= e6_doe_reg;
            e7_era_reg  <= e6_era_reg;
            e7_sec_reg  <= e6_sec_reg;
            e7_msec_reg <= e6_msec_reg;
        end
        if (adv[7])
        begin
            e8_yoe_reg  <= e8_yoe_next;
            e8_doe_reg  <= e7_doe_reg;
            e8_era_reg  <= e7_era_reg;
            e8_hour_reg <= e7_hour_reg;
            e8_min_reg  <= e7_min_reg;
            e8_sec_reg  <= e7_sec_reg;
            e8_msec_reg <= e7_msec_reg;
        end
        if (adv[8])
        begin
            e9_doy_reg  <= e9_doy_next;
            e9_year_reg <= e9_year_next;
            e9_hour_reg <= e8_hour_reg;
            e9_min_reg  <= e8_min_reg;
            e9_sec_reg  <= e8_sec_reg;
            e9_msec_reg <= e8_msec_reg;
        end
        if (adv[9])
        begin
            e10_mp_reg   <= e10_mp_next;
            e10_doy_reg  <= e9_doy_reg;
            e10_year_reg <= e9_year_reg;
            e10_hour_reg <= e9_hour_reg;
            e10_min_reg  <= e9_min_reg;
            e10_sec_reg  <= e9_sec_reg;
            e10_msec_reg <= e9_msec_reg;
        end
        if (adv[10])
        begin
            e11_mday_reg  <= e11_mday_next;
            e11_month_reg <= e11_month_next;
            e11_year_reg  <= e11_year_next;
            e11_hour_reg  <= e10_hour_reg;
            e11_min_reg   <= e10_min_reg;
            e11_sec_reg   <= e10_sec_reg;
            e11_msec_reg  <= e10_msec_reg;
        end
        if (adv[11])
        begin
            e12_word_reg <= e12_word_next;
        end
    end

    assign word = e12_word_reg;

endmodule

>>> hdl/emtc_dec.sv
module emtc_dec (
    input  logic                             clk,
    input  logic [emtc_pkg::NSTAGES-1:0]     adv,
    input  emtc_pkg::req_t                   req,
    output logic [42:0]                      ms
);
    import emtc_pkg::*;

    logic [3:0]  d0_monf;
    logic        d0_wrap;
    logic [3:0]  d0_monp;
    logic [7:0]  d0_y;
    logic        d0_c34;
    logic [16:0] d0_days;

    logic [15:0] d1_days_reg;
    logic [4:0]  d1_hour_reg;
    logic [5:0]  d1_min_reg;
    logic [15:0] d1_w16_reg;
    logic [20:0] d2_hm_reg, d2_hm_next;
    logic [5:0]  d2_min_reg;
    logic [15:0] d2_w16_reg;
    logic [26:0] d3_mins_reg, d3_mins_next;
    logic [15:0] d3_w16_reg;
    logic [32:0] d4_secs_reg, d4_secs_next;
    logic [15:0] d4_w16_reg;
    logic [42:0] d5_ms_reg, d5_ms_next;
    logic [42:0] dly_reg [DLY_STAGES];

    always_comb
    begin
        d0_monf = req.packed_time_in[43:40];
        d0_wrap = (d0_monf < 4'd3);
        d0_monp = d0_wrap ? (d0_monf + 4'd11) : (d0_monf - 4'd1);
        d0_y    = {1'b0, req.packed_time_in[54:48]} + 8'd100 - {7'd0, d0_wrap};
        d0_c34  = (d0_y >= 8'd200);
        d0_days = (({9'd0, d0_y} - 17'd69) * 17'd365) + {11'd0, d0_y[7:2]}
                + {8'd0, mon_days(d0_monp)} + {12'd0, req.packed_time_in[36:32]}
                - 17'd446 - {16'd0, d0_c34};

        d2_hm_next   = ({5'd0, d1_days_reg} * 21'd24) + {16'd0, d1_hour_reg};
        d3_mins_next = ({6'd0, d2_hm_reg} * 27'd60) + {21'd0, d2_min_reg};
        d4_secs_next = {6'd0, d3_mins_reg} * 33'd60;
        d5_ms_next   = 43'(({10'd0, d4_secs_reg} * 43'd1000) + {27'd0, d4_w16_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d1_days_reg <= d0_days[15:0];
            d1_hour_reg <= req.packed_time_in[28:24];
            d1_min_reg  <= req.packed_time_in[21:16];
            d1_w16_reg  <= req.packed_time_in[15:0];
        end
        if (adv[1])
        begin
            d2_hm_reg  <= d2_hm_next;
            d2_min_reg <= d1_min_reg;
            d2_w16_reg <= d1_w16_reg;
        end
        if (adv[2])
        begin
            d3_mins_reg <= d3_mins_next;
            d3_w16_reg  <= d2_w16_reg;
        end
        if (adv[3])
        begin
            d4_secs_reg <= d4_secs_next;
            d4_w16_reg  <= d3_w16_reg;
        end
        if (adv[4])
        begin
            d5_ms_reg <= d5_ms_next;
        end
        if (adv[DEC_STAGES])
        begin
            dly_reg[0] <= d5_ms_reg;
        end
        for (int k = 1; k < DLY_STAGES; k++)
        begin
            if (adv[DEC_STAGES + k])
            begin
                dly_reg[k] <= dly_reg[k - 1];
            end
        end
    end

    assign ms = dly_reg[DLY_STAGES - 1];

endmodule

>>> hdl/epoch_ms_seven_byte_time_codec.sv
// Converts between UTC milliseconds since 1970 and the seven-byte time word.
// A request enters on req_data when req_valid is high and req_stall is low.
// Its opcode selects encoding of epoch_ms_in into packed_time_out or decoding
// of packed_time_in into epoch_ms_out; the unused result field reads as zero.
// Each request produces exactly one result on rsp_data, offered with rsp_valid
// and taken when rsp_stall is low.
// The datapath is a twelve-stage pipeline in which every constant division is a
// reciprocal multiply followed by a one-step correction. rsp_valid rises when a
// request reaches the last stage, and one request can enter every cycle while
// req_stall is low.
// When the receiver stalls, the result holds and the stages behind it keep
// filling empty slots; req_stall rises only once every stage holds a request.
// Reset clears all valid bits, so the pipeline comes up empty and ready.
module epoch_ms_seven_byte_time_codec (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  emtc_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output emtc_pkg::rsp_t rsp_data
);
    import emtc_pkg::*;

    logic [NSTAGES:0]   en;
    logic [NSTAGES-1:0] v_reg;
    logic [NSTAGES-1:0] op_reg;
    logic [55:0]        enc_word;
    logic [42:0]        dec_ms;

    always_comb
    begin
        en[NSTAGES] = !rsp_stall;
        for (int k = NSTAGES - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= req_valid;
            end
            for (int k = 1; k < NSTAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op_reg[0] <= req_data.opcode;
        end
        for (int k = 1; k < NSTAGES; k++)
        begin
            if (en[k])
            begin
                op_reg[k] <= op_reg[k - 1];
            end
        end
    end

    emtc_enc u_enc (
        .clk  (clk),
        .adv  (en[NSTAGES-1:0]),
        .req  (req_data),
        .word (enc_word)
    );

    emtc_dec u_dec (
        .clk (clk),
        .adv (en[NSTAGES-1:0]),
        .req (req_data),
        .ms  (dec_ms)
    );

    assign req_stall = !en[0];
    assign rsp_valid = v_reg[NSTAGES - 1];

    always_comb
    begin
        if (op_reg[NSTAGES - 1] == OP_DECODE)
        begin
            rsp_data.packed_time_out = '0;
            rsp_data.epoch_ms_out    = dec_ms;
        end
        else
        begin
            rsp_data.packed_time_out = enc_word;
            rsp_data.epoch_ms_out    = '0;
        end
    end

endmodule
